// File: src/moving_average_deviation_alarm_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average deviation alarm unit
// Sampled on the rising edge of clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_DEVIATION_ALARM_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_DEVIATION_ALARM_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MADA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MADA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mada_pkg.sv
// ----------------------------------------------------------------------------
// mada_pkg
// Shared types and constants of the moving average deviation alarm unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mada_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [THRESH_W-1:0] thresh_t;

    // Threshold after reset
    localparam thresh_t THRESH_RESET = 16'd30;

endpackage

`default_nettype wire

// File: src/mada_cell.sv
// ----------------------------------------------------------------------------
// mada_cell
// One window cell: holds a pair average and hands it on when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module mada_cell
    import mada_pkg::*;
(
    input  wire     clk,
    input  wire     shift_en,
    input  sample_t data_in,
    output sample_t data_out
);

    sample_t value_reg;

    // Take the neighbour's value on every shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= data_in;
        end
    end

    assign data_out = value_reg;

endmodule

`default_nettype wire

// File: src/mada_cell_row.sv
// ----------------------------------------------------------------------------
// mada_cell_row
// Row of DEPTH cells forming the sample window; the tail is the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mada_cell_row
    import mada_pkg::*;
#(
    parameter int DEPTH = 10
)
(
    input  wire     clk,
    input  wire     shift_en,
    input  sample_t head,
    output sample_t tail
);

    sample_t link [DEPTH+1];

    assign link[0] = head;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mada_cell u_cell
        (
            .clk      (clk),
            .shift_en (shift_en),
            .data_in  (link[i]),
            .data_out (link[i+1])
        );
    end

    assign tail = link[DEPTH];

endmodule

`default_nettype wire

// File: src/moving_average_deviation_alarm_unit.sv
// ----------------------------------------------------------------------------
// moving_average_deviation_alarm_unit
// Moving average of paired sensor samples with a deviation alarm.
// ----------------------------------------------------------------------------
// Each request carries a right and a left sample. The unit takes one request
// per clock while sample_stall is low and returns one result per request, in
// order. The pair average enters a row of WINDOW cells that shift once per
// request; the cell at the far end holds the oldest entry, which drops out of
// a running sum as the new one comes in once the window is full. The window
// mean (truncated toward zero) is taken by a reciprocal multiply. The stages
// are: running sum, sum magnitude, multiply, mean and difference, then the
// output register with absolute deviation and threshold compare. For the
// first WINDOW requests compared, window_average, deviation and danger read
// zero. The threshold is written on the cfg channel, which is always ready;
// write it only while no request is in flight. A stall on the result side
// holds the pipeline only where stages are occupied, so empty stages keep
// taking requests.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_deviation_alarm_unit
    import mada_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  wire     clk,
    input  wire     rst_n,

    // Configuration write channel
    input  wire     cfg_valid,
    output logic    cfg_ready,
    input  thresh_t cfg_data,

    // Request channel
    input  wire     sample_valid,
    output logic    sample_stall,
    input  sample_t right_sample,
    input  sample_t left_sample,

    // Result channel
    output logic    result_valid,
    input  wire     result_stall,
    output sample_t pair_average,
    output sample_t window_average,
    output thresh_t deviation,
    output logic    compared,
    output logic    danger
);

    // ------------------------------------------------------------------
    // Derived widths. The sum magnitude never exceeds WINDOW * 2^15.
    // ------------------------------------------------------------------
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int MAG_W   = SAMPLE_W + LOG_W;
    localparam int SUM_W   = MAG_W + 1;
    localparam int SHIFT   = MAG_W + LOG_W;
    localparam int RECIP_W = MAG_W + 2;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int QUOT_W  = SAMPLE_W + 1;

    // ceil(2^SHIFT / WINDOW): exact floor division for any MAG_W-bit value
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [CNT_W-1:0] SEEN_FULL = CNT_W'(WINDOW);

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when empty or when the next advances
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic out_valid_reg, out_valid_next;

    logic en_out, en4, en3, en2, en1;
    logic accept;

    assign en_out = !out_valid_reg || !result_stall;
    assign en4    = !s4_valid_reg  || en_out;
    assign en3    = !s3_valid_reg  || en4;
    assign en2    = !s2_valid_reg  || en3;
    assign en1    = !s1_valid_reg  || en2;

    assign sample_stall = !en1;
    assign accept       = sample_valid && en1;

    assign s1_valid_next  = en1    ? accept       : s1_valid_reg;
    assign s2_valid_next  = en2    ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = en3    ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next  = en4    ? s3_valid_reg : s4_valid_reg;
    assign out_valid_next = en_out ? s4_valid_reg : out_valid_reg;

    // ------------------------------------------------------------------
    // Configuration: single register, always ready
    // ------------------------------------------------------------------
    thresh_t threshold_reg, threshold_next;

    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    // ------------------------------------------------------------------
    // Accept: pair average, window shift, running sum
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0] pair_sum;
    logic signed [SAMPLE_W:0] pair_adj;
    sample_t                  pair;
    sample_t                  oldest;
    logic                     full;

    logic [CNT_W-1:0]        seen_reg, seen_next;
    logic signed [SUM_W-1:0] run_sum_reg, run_sum_next;
    logic signed [SUM_W-1:0] drop_term;

    // Truncate toward zero: bump negative sums before the halving shift
    assign pair_sum = {right_sample[SAMPLE_W-1], right_sample}
                    + {left_sample[SAMPLE_W-1], left_sample};
    assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    assign pair     = pair_adj[SAMPLE_W:1];

    assign full = (seen_reg == SEEN_FULL);

    mada_cell_row #(
        .DEPTH (WINDOW)
    ) u_row (
        .clk      (clk),
        .shift_en (accept),
        .head     (pair),
        .tail     (oldest)
    );

    // Drop the oldest entry once the window is full
    assign drop_term = full ? SUM_W'(oldest) : '0;

    always_comb
    begin
        run_sum_next = run_sum_reg;
        seen_next    = seen_reg;
        if (accept)
        begin
            run_sum_next = run_sum_reg - drop_term + SUM_W'(pair);
            if (!full)
            begin
                seen_next = seen_reg + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    sample_t                 s1_pair_reg;
    logic                    s1_full_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;

    sample_t                 s2_pair_reg;
    logic                    s2_full_reg;
    logic                    s2_neg_reg;
    logic [MAG_W-1:0]        s2_mag_reg;
    logic signed [SUM_W-1:0] s2_mag_wide;

    sample_t                 s3_pair_reg;
    logic                    s3_full_reg;
    logic                    s3_neg_reg;
    logic [PROD_W-1:0]       s3_prod_reg;

    sample_t                  s4_pair_reg;
    logic                     s4_full_reg;
    sample_t                  s4_mean_reg;
    logic signed [QUOT_W-1:0] s4_diff_reg;
    logic [QUOT_W-1:0]        quot;
    logic signed [QUOT_W-1:0] mean_full;
    logic signed [QUOT_W-1:0] diff_next;

    sample_t                  pair_out_reg;
    sample_t                  mean_out_reg;
    thresh_t                  dev_out_reg;
    logic                     compared_out_reg;
    logic                     danger_out_reg;
    logic signed [QUOT_W-1:0] diff_abs;
    thresh_t                  dev_next;

    // Magnitude of the running sum
    assign s2_mag_wide = s1_sum_reg[SUM_W-1] ? -s1_sum_reg : s1_sum_reg;

    // Quotient, sign restore and difference to the pair average
    assign quot      = s3_prod_reg[SHIFT +: QUOT_W];
    assign mean_full = s3_neg_reg ? -$signed(quot) : $signed(quot);
    assign diff_next = mean_full - QUOT_W'(s3_pair_reg);

    // Absolute deviation
    assign diff_abs = s4_diff_reg[QUOT_W-1] ? -s4_diff_reg : s4_diff_reg;
    assign dev_next = diff_abs[THRESH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pair_reg <= pair;
            s1_full_reg <= full;
            s1_sum_reg  <= run_sum_next;
        end
        if (en2)
        begin
            s2_pair_reg <= s1_pair_reg;
            s2_full_reg <= s1_full_reg;
            s2_neg_reg  <= s1_sum_reg[SUM_W-1];
            s2_mag_reg  <= s2_mag_wide[MAG_W-1:0];
        end
        if (en3)
        begin
            s3_pair_reg <= s2_pair_reg;
            s3_full_reg <= s2_full_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_prod_reg <= PROD_W'(s2_mag_reg) * PROD_W'(RECIP);
        end
        if (en4)
        begin
            s4_pair_reg <= s3_pair_reg;
            s4_full_reg <= s3_full_reg;
            // Warm-up: report zero mean and difference
            s4_mean_reg <= s3_full_reg ? mean_full[SAMPLE_W-1:0] : '0;
            s4_diff_reg <= s3_full_reg ? diff_next : '0;
        end
        if (en_out)
        begin
            pair_out_reg     <= s4_pair_reg;
            mean_out_reg     <= s4_mean_reg;
            dev_out_reg      <= dev_next;
            compared_out_reg <= s4_full_reg;
            danger_out_reg   <= s4_full_reg && (dev_next > threshold_reg);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            run_sum_reg   <= '0;
            threshold_reg <= THRESH_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            run_sum_reg   <= run_sum_next;
            threshold_reg <= threshold_next;
        end
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign result_valid   = out_valid_reg;
    assign pair_average   = pair_out_reg;
    assign window_average = mean_out_reg;
    assign deviation      = dev_out_reg;
    assign compared       = compared_out_reg;
    assign danger         = danger_out_reg;

endmodule

`default_nettype wire

// File: src/mada_checker.sv
// ----------------------------------------------------------------------------
// mada_checker
// Port-level checks of the moving average deviation alarm unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_deviation_alarm_unit_assert.svh"

module mada_checker
    import mada_pkg::*;
(
    input wire     clk,
    input wire     rst_n,
    input wire     sample_stall,
    input wire     result_valid,
    input wire     result_stall,
    input sample_t pair_average,
    input sample_t window_average,
    input thresh_t deviation,
    input wire     compared,
    input wire     danger
);

    // Hold a stalled result unchanged
    `MADA_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(pair_average) && $stable(window_average)
        && $stable(deviation) && $stable(danger), "stalled result changed")

    // Empty output register must never back-pressure requests
    `MADA_ASSERT_SAME(a_no_idle_stall, !result_valid, !sample_stall,
        "request stalled with no result pending")

    // Warm-up results carry no comparison
    `MADA_ASSERT_SAME(a_warmup_zero, result_valid && !compared,
        window_average == '0 && deviation == '0 && !danger,
        "warm-up result carries comparison data")

    // Danger only with a comparison and a nonzero deviation
    `MADA_ASSERT_SAME(a_danger_cause, result_valid && danger,
        compared && deviation != '0, "danger without cause")

endmodule

bind moving_average_deviation_alarm_unit mada_checker u_mada_checker (.*);

`default_nettype wire
